@@ src/wcbu_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the weighted color blend unit.
// No dependencies; imported by weighted_color_blend_unit.
package wcbu_pkg;

  localparam int MODE_W = 4;
  localparam int NUM_CH = 5;
  localparam int OP_W   = 32;
  localparam int PROD_W = 64;

  localparam longint OP_MAX = 64'sd2147483647;
  localparam longint OP_MIN = -64'sd2147483648;

  typedef enum logic [MODE_W-1:0] {
    MODE_MIX        = 4'd0,
    MODE_ADD        = 4'd1,
    MODE_MULTIPLY   = 4'd2,
    MODE_SUBTRACT   = 4'd3,
    MODE_SCREEN     = 4'd4,
    MODE_DIFFERENCE = 4'd5,
    MODE_DARKEN     = 4'd6,
    MODE_LIGHTEN    = 4'd7,
    MODE_OVERLAY    = 4'd8
  } blend_mode_t;

endpackage

@@ src/weighted_color_blend_unit.sv @@
`timescale 1ns / 1ps
// Top level of the weighted color blend unit: a five-stage pipeline that blends
// two RGBA colors plus a scalar under a factor. Depends on wcbu_pkg.
//
// Usage: each request on the in_ stream carries two colors with a scalar each
// and the factor f2; the out_ stream returns one blended result per request.
// The blend mode is written through cfg_wr_en/cfg_wr_data; the user must write it
// only while no request is in flight, as the block does not enforce this. The
// mode applies to all five channels alike. One request is accepted every cycle
// while the output is not stalled.
// The pipeline depth is set by the chain of two dependent rounded products (inner
// product, then outer product) cut into five register stages, with at most one
// multiply on any path between two registers.
// Each stage carries a valid bit. When out_tready is low the output stage
// holds its result and earlier stages keep filling bubbles; in_tready drops
// only once every stage holds a request, so nothing is lost or repeated.
// Reset clears all valid bits and sets the mode to mix.
module weighted_color_blend_unit
  import wcbu_pkg::*;
#(
  parameter int FRAC_BITS     = 12,
  parameter int CHANNEL_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [MODE_W-1:0]     cfg_wr_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // first_red, first_green, first_blue, first_alpha, first_scalar,
  // second_red, second_green, second_blue, second_alpha, second_scalar,
  // mix_factor, zero fill
  input  logic [((10*CHANNEL_WIDTH+FRAC_BITS+1+7)/8)*8-1:0] in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_red, out_green, out_blue, out_alpha, out_scalar, zero fill
  output logic [((5*CHANNEL_WIDTH+7)/8)*8-1:0] out_tdata
);

  localparam int CW       = CHANNEL_WIDTH;
  localparam int FW       = FRAC_BITS + 1;
  localparam int FXW      = FRAC_BITS + 3;
  localparam int EW       = PROD_W + 1 - FRAC_BITS;
  localparam int NST      = 5;

  localparam longint ONE_L  = 64'sd1 <<< FRAC_BITS;
  localparam longint HALF_L = ONE_L / 2;
  localparam longint CMAX_L = (64'sd1 <<< (CHANNEL_WIDTH - 1)) - 64'sd1;
  localparam longint CMIN_L = -(64'sd1 <<< (CHANNEL_WIDTH - 1));

  localparam logic [FW-1:0]            ONE_F     = FW'(ONE_L);
  localparam logic signed [EW-1:0]     ONE_E     = EW'(ONE_L);
  localparam logic signed [EW-1:0]     HALF_E    = EW'(HALF_L);
  localparam logic signed [PROD_W-1:0] HALF_P    = PROD_W'(HALF_L);
  localparam logic signed [EW-1:0]     OP_MAX_E  = EW'(OP_MAX);
  localparam logic signed [EW-1:0]     OP_MIN_E  = EW'(OP_MIN);
  localparam logic signed [EW-1:0]     CH_MAX_E  = EW'(CMAX_L);
  localparam logic signed [EW-1:0]     CH_MIN_E  = EW'(CMIN_L);
  localparam logic signed [FXW-1:0]    X1_MAX    = FXW'(2 * ONE_L);

  function automatic logic signed [OP_W-1:0] sat_op(input logic signed [EW-1:0] x);
    logic signed [EW-1:0] y;
    y = x;
    if (x > OP_MAX_E) y = OP_MAX_E;
    if (x < OP_MIN_E) y = OP_MIN_E;
    return OP_W'(y);
  endfunction

  function automatic logic signed [CW-1:0] sat_ch(input logic signed [EW-1:0] x);
    logic signed [EW-1:0] y;
    y = x;
    if (x > CH_MAX_E) y = CH_MAX_E;
    if (x < CH_MIN_E) y = CH_MIN_E;
    return CW'(y);
  endfunction

  blend_mode_t blend_mode_r;
  logic [NST-1:0] vld_r;
  logic [NST:0]   rdy;

  // Stage 0 inputs.
  logic [FW-1:0]          fac_in;
  logic [FW-1:0]          f2_in;
  logic [FW:0]            f2x_in;
  logic                   is_ovl;
  logic signed [EW-1:0]   a_e   [NUM_CH];
  logic signed [EW-1:0]   b_e   [NUM_CH];
  logic signed [EW-1:0]   dif_e [NUM_CH];
  logic signed [EW-1:0]   y1_e  [NUM_CH];
  logic                   inv_in [NUM_CH];

  logic signed [FXW-1:0]  s0_x1_r, s0_x1_nxt;
  logic signed [FW:0]     s0_f1_r, s0_f1_nxt;
  logic signed [OP_W-1:0] s0_y1_r  [NUM_CH];
  logic signed [CW-1:0]   s0_a_r   [NUM_CH];
  logic                   s0_inv_r [NUM_CH];

  // Stage 1: first products.
  logic signed [FXW+OP_W-1:0] p1_full [NUM_CH];
  logic signed [FW+1+CW-1:0]  p2_full [NUM_CH];
  logic signed [PROD_W-1:0]   s1_p1_r [NUM_CH];
  logic signed [PROD_W-1:0]   s1_p2_r [NUM_CH];
  logic signed [CW-1:0]       s1_a_r  [NUM_CH];
  logic                       s1_inv_r [NUM_CH];
  logic signed [FW:0]         s1_f1_r;

  // Stage 2: rounding and outer operands.
  logic signed [EW-1:0]   s2_m1_nxt [NUM_CH];
  logic signed [EW-1:0]   s2_m1_r   [NUM_CH];
  logic signed [EW-1:0]   s2_m2_r   [NUM_CH];
  logic signed [OP_W-1:0] s2_u_r    [NUM_CH];
  logic signed [OP_W-1:0] s2_v_r    [NUM_CH];
  logic signed [CW-1:0]   s2_a_r    [NUM_CH];
  logic                   s2_inv_r  [NUM_CH];

  // Stage 3: outer product and linear results.
  logic signed [EW-1:0]     s2_ae     [NUM_CH];
  logic signed [EW-1:0]     s3_alt_nxt [NUM_CH];
  logic signed [PROD_W-1:0] s3_p3_r   [NUM_CH];
  logic signed [EW-1:0]     s3_alt_r  [NUM_CH];
  logic                     s3_inv_r  [NUM_CH];

  // Stage 4: final select and saturation.
  logic                   use_mul;
  logic signed [EW-1:0]   m3    [NUM_CH];
  logic signed [EW-1:0]   res_e [NUM_CH];
  logic signed [CW-1:0]   out_ch_r [NUM_CH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blend_mode_r <= MODE_MIX;
    end else if (cfg_wr_en) begin
      blend_mode_r <= blend_mode_t'(cfg_wr_data);
    end
  end

  always_comb begin
    rdy[NST] = out_tready;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_tready  = rdy[0];
  assign out_tvalid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) vld_r[0] <= in_tvalid;
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_comb begin
    fac_in    = in_tdata[2*NUM_CH*CW +: FW];
    f2_in     = (fac_in > ONE_F) ? ONE_F : fac_in;
    is_ovl    = (blend_mode_r == MODE_OVERLAY);
    f2x_in    = is_ovl ? {f2_in, 1'b0} : {1'b0, f2_in};
    s0_x1_nxt = signed'({1'b0, f2x_in});
    s0_f1_nxt = signed'({1'b0, ONE_F - f2_in});
    for (int i = 0; i < NUM_CH; i++) begin
      a_e[i]    = EW'($signed(in_tdata[i*CW +: CW]));
      b_e[i]    = EW'($signed(in_tdata[(NUM_CH+i)*CW +: CW]));
      dif_e[i]  = a_e[i] - b_e[i];
      inv_in[i] = (blend_mode_r == MODE_SCREEN) || (is_ovl && !(a_e[i] < HALF_E));
      case (blend_mode_r)
        MODE_SCREEN, MODE_OVERLAY: y1_e[i] = inv_in[i] ? (ONE_E - b_e[i]) : b_e[i];
        MODE_DIFFERENCE:           y1_e[i] = (dif_e[i] < 0) ? -dif_e[i] : dif_e[i];
        default:                   y1_e[i] = b_e[i];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s0_x1_r <= s0_x1_nxt;
      s0_f1_r <= s0_f1_nxt;
      for (int i = 0; i < NUM_CH; i++) begin
        s0_y1_r[i]  <= sat_op(y1_e[i]);
        s0_a_r[i]   <= CW'(a_e[i]);
        s0_inv_r[i] <= inv_in[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      p1_full[i] = s0_x1_r * s0_y1_r[i];
      p2_full[i] = s0_f1_r * s0_a_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_f1_r <= s0_f1_r;
      for (int i = 0; i < NUM_CH; i++) begin
        s1_p1_r[i]  <= PROD_W'(p1_full[i]);
        s1_p2_r[i]  <= PROD_W'(p2_full[i]);
        s1_a_r[i]   <= s0_a_r[i];
        s1_inv_r[i] <= s0_inv_r[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      s2_m1_nxt[i] = EW'((s1_p1_r[i] + HALF_P) >>> FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      for (int i = 0; i < NUM_CH; i++) begin
        s2_m1_r[i]  <= s2_m1_nxt[i];
        s2_m2_r[i]  <= EW'((s1_p2_r[i] + HALF_P) >>> FRAC_BITS);
        s2_u_r[i]   <= sat_op(EW'(s1_f1_r) + s2_m1_nxt[i]);
        s2_v_r[i]   <= s1_inv_r[i] ? sat_op(ONE_E - EW'(s1_a_r[i])) : OP_W'(s1_a_r[i]);
        s2_a_r[i]   <= s1_a_r[i];
        s2_inv_r[i] <= s1_inv_r[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      s2_ae[i] = EW'(s2_a_r[i]);
      case (blend_mode_r)
        MODE_ADD:      s3_alt_nxt[i] = s2_ae[i] + s2_m1_r[i];
        MODE_SUBTRACT: s3_alt_nxt[i] = s2_ae[i] - s2_m1_r[i];
        MODE_DARKEN:   s3_alt_nxt[i] = (s2_m1_r[i] < s2_ae[i]) ? s2_m1_r[i] : s2_ae[i];
        MODE_LIGHTEN:  s3_alt_nxt[i] = (s2_m1_r[i] > s2_ae[i]) ? s2_m1_r[i] : s2_ae[i];
        default:       s3_alt_nxt[i] = s2_m1_r[i] + s2_m2_r[i];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int i = 0; i < NUM_CH; i++) begin
        s3_p3_r[i]  <= s2_u_r[i] * s2_v_r[i];
        s3_alt_r[i] <= s3_alt_nxt[i];
        s3_inv_r[i] <= s2_inv_r[i];
      end
    end
  end

  always_comb begin
    case (blend_mode_r)
      MODE_MULTIPLY, MODE_SCREEN, MODE_OVERLAY: use_mul = 1'b1;
      default:                                  use_mul = 1'b0;
    endcase
    for (int i = 0; i < NUM_CH; i++) begin
      m3[i]    = EW'((s3_p3_r[i] + HALF_P) >>> FRAC_BITS);
      res_e[i] = use_mul ? (s3_inv_r[i] ? (ONE_E - m3[i]) : m3[i]) : s3_alt_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      for (int i = 0; i < NUM_CH; i++) begin
        out_ch_r[i] <= sat_ch(res_e[i]);
      end
    end
  end

  always_comb begin
    out_tdata = '0;
    for (int i = 0; i < NUM_CH; i++) begin
      out_tdata[i*CW +: CW] = out_ch_r[i];
    end
  end

  // The input side stalls only when every stage is occupied and the output is blocked.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (&vld_r) && !out_tready)
    else $error("input stalled while the pipeline has room");

  // The scaled factor entering the first product never exceeds twice one.
  assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] |-> (s0_x1_r >= 0) && (s0_x1_r <= X1_MAX))
    else $error("first product factor out of range");

  // A stalled outer product keeps its value.
  assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[3] && !rdy[4] |=> vld_r[3] && $stable(s3_p3_r[0]))
    else $error("stalled stage lost its product");

  // The inverted outer form is only used by screen and overlay.
  assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[3] && s3_inv_r[0] |->
      (blend_mode_r == MODE_SCREEN) || (blend_mode_r == MODE_OVERLAY))
    else $error("inverted result flagged outside screen or overlay");

endmodule
